/* hdl/svt_pkg.sv */
// shared types and constants for the summed volume table block
package svt_pkg;

    localparam int SUM_W      = 64;
    localparam int VOXEL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SIZE_XY_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    // position flags that travel with each voxel through the pipeline
    typedef struct packed {
        logic first_x;
        logic first_y;
        logic first_z;
        logic last;
    } svt_tag_t;

endpackage

/* hdl/svt_ram.sv */
// generic simple dual-port ram with registered read, read-first on collision
module svt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/svt_ctrl.sv */
// size registers and raster position counters for the summed volume table
module svt_ctrl #(
    parameter int MAX_X = 128,
    parameter int MAX_Y = 128,
    parameter int MAX_Z = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [svt_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [svt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             step,
    output logic [$clog2(MAX_X)-1:0]         cur_x,
    output logic [$clog2(MAX_X*MAX_Y)-1:0]   cur_idx,
    output svt_pkg::svt_tag_t                cur_tag
);

    localparam int PXW = $clog2(MAX_X);
    localparam int PYW = $clog2(MAX_Y);
    localparam int PZW = $clog2(MAX_Z);
    localparam int IW  = $clog2(MAX_X * MAX_Y);
    localparam int SXW = $clog2(MAX_X + 1);
    localparam int SYW = $clog2(MAX_Y + 1);
    localparam int SZW = $clog2(MAX_Z + 1);
    localparam int SX_RST = (MAX_X < 128) ? MAX_X : 128;
    localparam int SY_RST = (MAX_Y < 128) ? MAX_Y : 128;
    localparam int SZ_RST = (MAX_Z < 1024) ? MAX_Z : 1024;

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
        int unsigned r;
        if (v == 0) begin
            r = 1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [SXW-1:0] size_x_reg, size_x_next;
    logic [SYW-1:0] size_y_reg, size_y_next;
    logic [SZW-1:0] size_z_reg, size_z_next;
    logic [PXW-1:0] pos_x_reg, pos_x_next;
    logic [PYW-1:0] pos_y_reg, pos_y_next;
    logic [PZW-1:0] pos_z_reg, pos_z_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [IW-1:0]  row_base_reg, row_base_next;
    logic [31:0]    x_inc, y_inc, z_inc;
    logic           end_x, end_y, end_z;

    assign x_inc = 32'(pos_x_reg) + 32'd1;
    assign y_inc = 32'(pos_y_reg) + 32'd1;
    assign z_inc = 32'(pos_z_reg) + 32'd1;
    assign end_x = (x_inc >= 32'(size_x_reg));
    assign end_y = (y_inc >= 32'(size_y_reg));
    assign end_z = (z_inc >= 32'(size_z_reg));

    always_comb begin
        size_x_next   = size_x_reg;
        size_y_next   = size_y_reg;
        size_z_next   = size_z_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg;
        idx_next      = idx_reg;
        row_base_next = row_base_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                svt_pkg::CFG_SIZE_X: begin
                    size_x_next = SXW'(clamp_size(32'(cfg_wdata[svt_pkg::SIZE_XY_W-1:0]),
                                                  MAX_X));
                end
                svt_pkg::CFG_SIZE_Y: begin
                    size_y_next = SYW'(clamp_size(32'(cfg_wdata[svt_pkg::SIZE_XY_W-1:0]),
                                                  MAX_Y));
                end
                svt_pkg::CFG_SIZE_Z: begin
                    size_z_next = SZW'(clamp_size(32'(cfg_wdata), MAX_Z));
                end
                default: begin
                end
            endcase
            // any known register write restarts the volume
            if (cfg_addr == svt_pkg::CFG_SIZE_X || cfg_addr == svt_pkg::CFG_SIZE_Y ||
                cfg_addr == svt_pkg::CFG_SIZE_Z) begin
                pos_x_next    = '0;
                pos_y_next    = '0;
                pos_z_next    = '0;
                idx_next      = '0;
                row_base_next = '0;
            end
        end else if (step) begin
            if (!end_x) begin
                pos_x_next = PXW'(x_inc);
                idx_next   = idx_reg + IW'(1);
            end else begin
                pos_x_next = '0;
                if (!end_y) begin
                    pos_y_next    = PYW'(y_inc);
                    row_base_next = row_base_reg + IW'(MAX_X);
                    idx_next      = row_base_reg + IW'(MAX_X);
                end else begin
                    pos_y_next    = '0;
                    row_base_next = '0;
                    idx_next      = '0;
                    pos_z_next    = end_z ? '0 : PZW'(z_inc);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg   <= SXW'(SX_RST);
            size_y_reg   <= SYW'(SY_RST);
            size_z_reg   <= SZW'(SZ_RST);
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            idx_reg      <= '0;
            row_base_reg <= '0;
        end else begin
            size_x_reg   <= size_x_next;
            size_y_reg   <= size_y_next;
            size_z_reg   <= size_z_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_z_reg    <= pos_z_next;
            idx_reg      <= idx_next;
            row_base_reg <= row_base_next;
        end
    end

    assign cur_x           = pos_x_reg;
    assign cur_idx         = idx_reg;
    assign cur_tag.first_x = (pos_x_reg == '0);
    assign cur_tag.first_y = (pos_y_reg == '0);
    assign cur_tag.first_z = (pos_z_reg == '0);
    assign cur_tag.last    = end_x && end_y && end_z;

endmodule

/* hdl/summed_volume_table_3d_top.sv */
// top level of the streaming 3d summed volume table
// a result word passes from the input register through the row and column stages to the output register
// throughput: one voxel per cycle unless m_tready or a config write stalls it; four stages, three adds
// stalls on m_tready ripple back stage by stage; bubbles are squeezed out while stalled
// reset: synchronous active-low aresetn empties the pipeline, zeros positions and loads
//   sizes of 128 x 128 x 1024 (capped at the maximums); the stores need no clearing
module summed_volume_table_3d_top #(
    parameter int MAX_X = 128,
    parameter int MAX_Y = 128,
    parameter int MAX_Z = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [svt_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [svt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // voxel input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [svt_pkg::VOXEL_W-1:0]     s_tdata,   // [31:0] voxel
    // integral output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [svt_pkg::SUM_W-1:0]       m_tdata,   // [63:0] volume_sum
    output logic                            m_tlast    // last_voxel
);

    localparam int PXW   = $clog2(MAX_X);
    localparam int IW    = $clog2(MAX_X * MAX_Y);
    localparam int PLANE = MAX_X * MAX_Y;

    // handshakes
    logic s_accept;
    logic cfg_we;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign s_accept  = s_tvalid && s_tready;

    // position of the voxel being accepted now
    logic [PXW-1:0]    cur_x;
    logic [IW-1:0]     cur_idx;
    svt_pkg::svt_tag_t cur_tag;

    svt_ctrl #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (s_accept),
        .cur_x     (cur_x),
        .cur_idx   (cur_idx),
        .cur_tag   (cur_tag)
    );

    // stage valids
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic move0, move1, move2;

    // stage 0: input register
    logic signed [svt_pkg::VOXEL_W-1:0] s0_voxel_reg;
    logic [PXW-1:0]                     s0_x_reg;
    logic [IW-1:0]                      s0_idx_reg;
    svt_pkg::svt_tag_t                  s0_tag_reg;

    // stage 1: row sum (also serves as the running row register)
    logic [svt_pkg::SUM_W-1:0] s1_row_reg;
    logic [PXW-1:0]            s1_x_reg;
    logic [IW-1:0]             s1_idx_reg;
    svt_pkg::svt_tag_t         s1_tag_reg;

    // stage 2: column sum
    logic [svt_pkg::SUM_W-1:0] s2_col_reg;
    logic [PXW-1:0]            s2_x_reg;
    logic [IW-1:0]             s2_idx_reg;
    svt_pkg::svt_tag_t         s2_tag_reg;

    // stage 3: output register, plane sum
    logic [svt_pkg::SUM_W-1:0] s3_plane_reg;
    logic [IW-1:0]             s3_idx_reg;
    logic                      s3_last_reg;

    // each stage moves when the one after it is free or moving
    assign move2    = v2_reg && (!v3_reg || m_tready);
    assign move1    = v1_reg && (!v2_reg || move2);
    assign move0    = v0_reg && (!v1_reg || move1);
    // a pending config write holds off new voxels and lands once the pipeline is empty
    assign s_tready = (!v0_reg || move0) && !cfg_valid;
    assign cfg_ready = !(v0_reg || v1_reg || v2_reg || v3_reg);

    // row: restart at the start of each row
    logic [svt_pkg::SUM_W-1:0] voxel_ext;
    logic [svt_pkg::SUM_W-1:0] row_next;
    assign voxel_ext = {{(svt_pkg::SUM_W - svt_pkg::VOXEL_W){s0_voxel_reg[svt_pkg::VOXEL_W-1]}},
                        s0_voxel_reg};
    assign row_next  = s0_tag_reg.first_x ? voxel_ext : s1_row_reg + voxel_ext;

    // column line store, addressed by the voxel entering stage 1 so its registered read is ready for stage 1
    logic [svt_pkg::SUM_W-1:0] col_rd;
    logic [svt_pkg::SUM_W-1:0] col_prev;
    logic [svt_pkg::SUM_W-1:0] col_next;
    logic [PXW-1:0]            col_raddr;

    assign col_raddr = move0 ? s0_x_reg : s1_x_reg;
    // stage 2 holds the newest column write; the ram may not have it yet
    assign col_prev  = (s2_x_reg == s1_x_reg) ? s2_col_reg : col_rd;
    assign col_next  = s1_tag_reg.first_y ? s1_row_reg : col_prev + s1_row_reg;

    svt_ram #(
        .WIDTH (svt_pkg::SUM_W),
        .DEPTH (MAX_X)
    ) u_column_line (
        .aclk    (aclk),
        .wr_en   (move1),
        .wr_addr (s1_x_reg),
        .wr_data (col_next),
        .rd_addr (col_raddr),
        .rd_data (col_rd)
    );

    // plane store, same scheme one stage later
    logic [svt_pkg::SUM_W-1:0] plane_rd;
    logic [svt_pkg::SUM_W-1:0] plane_prev;
    logic [svt_pkg::SUM_W-1:0] plane_next;
    logic [IW-1:0]             plane_raddr;

    assign plane_raddr = move1 ? s1_idx_reg : s2_idx_reg;
    // output register holds the newest plane write
    assign plane_prev  = (s3_idx_reg == s2_idx_reg) ? s3_plane_reg : plane_rd;
    assign plane_next  = s2_tag_reg.first_z ? s2_col_reg : plane_prev + s2_col_reg;

    svt_ram #(
        .WIDTH (svt_pkg::SUM_W),
        .DEPTH (PLANE)
    ) u_plane_store (
        .aclk    (aclk),
        .wr_en   (move2),
        .wr_addr (s2_idx_reg),
        .wr_data (plane_next),
        .rd_addr (plane_raddr),
        .rd_data (plane_rd)
    );

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= s_accept || (v0_reg && !move0);
            v1_reg <= move0 || (v1_reg && !move1);
            v2_reg <= move1 || (v2_reg && !move2);
            v3_reg <= move2 || (v3_reg && !m_tready);
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s0_voxel_reg <= s_tdata;
            s0_x_reg     <= cur_x;
            s0_idx_reg   <= cur_idx;
            s0_tag_reg   <= cur_tag;
        end
        if (move0) begin
            s1_row_reg <= row_next;
            s1_x_reg   <= s0_x_reg;
            s1_idx_reg <= s0_idx_reg;
            s1_tag_reg <= s0_tag_reg;
        end
        if (move1) begin
            s2_col_reg <= col_next;
            s2_x_reg   <= s1_x_reg;
            s2_idx_reg <= s1_idx_reg;
            s2_tag_reg <= s1_tag_reg;
        end
        if (move2) begin
            s3_plane_reg <= plane_next;
            s3_idx_reg   <= s2_idx_reg;
            s3_last_reg  <= s2_tag_reg.last;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = s3_plane_reg;
    assign m_tlast  = s3_last_reg;

    // an empty output register with no config write pending means the whole pipeline can take a word
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !cfg_valid) |-> s_tready)
        else $error("input stalled with empty output register");

    // apart from a pending config write, input only stalls when every stage is full and the output is held
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && !cfg_valid) |-> (v0_reg && v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled with a free stage");

    // the word after the last voxel of a volume starts a new volume
    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && cur_tag.last) |=>
            (cur_tag.first_x && cur_tag.first_y && cur_tag.first_z))
        else $error("positions did not wrap after last voxel");

endmodule

/* sim/tb_summed_volume_table_3d_top.sv */
// testbench for the streaming 3d summed volume table: directed and random stimulus checked against a predictor
`timescale 1ns / 100ps

module tb_summed_volume_table_3d_top;

    localparam int MAX_X = 128;
    localparam int MAX_Y = 128;
    localparam int MAX_Z = 1024;

    typedef logic [svt_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [svt_pkg::CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [svt_pkg::VOXEL_W-1:0]    voxel_t;
    typedef logic [svt_pkg::SUM_W-1:0]      sum_t;

    // index with no register behind it: the write is taken and dropped
    localparam cfg_idx_t CFG_NO_REG = 2'd3;

    // one expected output word
    typedef struct packed {
        sum_t sum;
        logic last;
    } integral_t;

    logic      aclk;
    logic      aresetn;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_idx_t  cfg_addr;
    cfg_data_t cfg_wdata;
    logic      s_tvalid;
    logic      s_tready;
    voxel_t    s_tdata;     // [31:0] voxel
    logic      m_tvalid;
    logic      m_tready;
    sum_t      m_tdata;     // [63:0] volume_sum
    logic      m_tlast;     // last_voxel

    summed_volume_table_3d_top #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y),
        .MAX_Z(MAX_Z)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // predictor state: volume sizes, position of the next voxel and the three stages of sums
    int unsigned vol_x, vol_y, vol_z;
    int unsigned at_x, at_y, at_z;
    sum_t        row_acc;
    sum_t        column_acc [MAX_X];
    sum_t        plane_acc  [MAX_X*MAX_Y];

    integral_t sums_due[$];     // integrals still to come out, oldest first
    integral_t sum_want;
    int        errors;
    bit        no_gaps;         // set for stretches where the sender never idles

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit, well above the slowest legal run
    initial begin
        #10_000_000;
        $display("FAIL summed_volume_table_3d_top");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // zero means one, anything past the maximum saturates
    function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void restart_volume();
        row_acc = '0;
        at_x    = 0;
        at_y    = 0;
        at_z    = 0;
    endfunction

    function automatic void apply_reg(cfg_idx_t addr, cfg_data_t data);
        case (addr)
            svt_pkg::CFG_SIZE_X: begin
                vol_x = clamp_size(data[svt_pkg::SIZE_XY_W-1:0], MAX_X);
                restart_volume();
            end
            svt_pkg::CFG_SIZE_Y: begin
                vol_y = clamp_size(data[svt_pkg::SIZE_XY_W-1:0], MAX_Y);
                restart_volume();
            end
            svt_pkg::CFG_SIZE_Z: begin
                vol_z = clamp_size(data, MAX_Z);
                restart_volume();
            end
            default: ;  // no register, position is kept
        endcase
    endfunction

    // row sum, then column sum over y, then plane sum over z; advances the position
    function automatic integral_t integrate_voxel(voxel_t voxel);
        sum_t        v;
        sum_t        col;
        sum_t        pl;
        int unsigned idx;
        bit          end_x, end_y, end_z;
        integral_t   res;
        v       = {{(svt_pkg::SUM_W-svt_pkg::VOXEL_W){voxel[svt_pkg::VOXEL_W-1]}}, voxel};
        row_acc = (at_x == 0) ? v : row_acc + v;
        col     = (at_y == 0) ? row_acc : column_acc[at_x] + row_acc;
        column_acc[at_x] = col;
        idx     = at_y * MAX_X + at_x;
        pl      = (at_z == 0) ? col : plane_acc[idx] + col;
        plane_acc[idx] = pl;
        end_x   = (at_x + 1 >= vol_x);
        end_y   = (at_y + 1 >= vol_y);
        end_z   = (at_z + 1 >= vol_z);
        res.sum  = pl;
        res.last = end_x && end_y && end_z;
        if (!end_x) begin
            at_x = at_x + 1;
        end else begin
            at_x = 0;
            if (!end_y) begin
                at_y = at_y + 1;
            end else begin
                at_y = 0;
                at_z = end_z ? 0 : at_z + 1;
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // full-range values mixed with small signed ones and values near the extremes
    function automatic voxel_t rand_voxel();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom();
        if (r < 70) return $urandom_range(0, 16) - 8;
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        if (r[0]) return 32'h7FFF_FFFF - $urandom_range(0, 255);
        return 32'h8000_0000 + $urandom_range(0, 255);
    endfunction

    // called in the step of the previous handshake; valid stays up for a back-to-back word
    task automatic send_voxel(input voxel_t voxel);
        int unsigned gap;
        gap = pick_gap();
        cfg_valid <= 1'b0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= voxel;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sums_due.push_back(integrate_voxel(voxel));
    endtask

    // register writes only once every pending word has come out
    task automatic write_reg(input cfg_idx_t addr, input cfg_data_t data);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        repeat (1 + pick_gap()) @(posedge aclk);
        while (sums_due.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(addr, data);
    endtask

    task automatic set_volume(input int unsigned nx, input int unsigned ny, input int unsigned nz);
        write_reg(svt_pkg::CFG_SIZE_X, cfg_data_t'(nx));
        write_reg(svt_pkg::CFG_SIZE_Y, cfg_data_t'(ny));
        write_reg(svt_pkg::CFG_SIZE_Z, cfg_data_t'(nz));
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset sizes are 128 x 128 x 1024; go past the first row so the column line is read
    task automatic test_reset_sizes();
        no_gaps = 1'b0;
        repeat (MAX_X + 2) send_voxel(rand_voxel());
    endtask

    // extreme voxel values, restart on a write, dropped write, zero sizes
    task automatic test_directed();
        voxel_t edge_vals [8];
        edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
        no_gaps = 1'b0;
        set_volume(2, 2, 2);
        // write to the unused index in mid volume must not restart it
        for (int i = 0; i < 3; i++) send_voxel(edge_vals[i]);
        write_reg(CFG_NO_REG, 11'h7FF);
        for (int i = 3; i < 8; i++) send_voxel(edge_vals[i]);
        // a real write in mid volume restarts it
        for (int i = 0; i < 3; i++) send_voxel(edge_vals[7-i]);
        write_reg(svt_pkg::CFG_SIZE_Y, 11'd2);
        for (int i = 0; i < 8; i++) send_voxel(edge_vals[i]);
        // zero sizes give a one-voxel volume, every word is last
        set_volume(0, 0, 0);
        send_voxel(32'h8000_0000);
        send_voxel(32'h7FFF_FFFF);
        send_voxel(32'hFFFF_FFFF);
    endtask

    // full-length row, upper data bits above the 8-bit size field are dropped
    task automatic test_size_x_max();
        no_gaps = 1'b0;
        write_reg(svt_pkg::CFG_SIZE_X, 11'h780);
        write_reg(svt_pkg::CFG_SIZE_Y, 11'd1);
        write_reg(svt_pkg::CFG_SIZE_Z, 11'd1);
        repeat (MAX_X + 3) send_voxel(rand_voxel());
    endtask

    // over-range row count saturates to the maximum
    task automatic test_size_y_max();
        no_gaps = 1'b0;
        set_volume(1, 200, 1);
        repeat (MAX_Y + 2) send_voxel(rand_voxel());
    endtask

    // over-range plane count saturates; run one full volume and wrap into the next
    task automatic test_size_z_max();
        set_volume(1, 1, 11'h7FF);
        for (int i = 0; i < MAX_Z + 2; i++) begin
            no_gaps = (i < 300);
            send_voxel(rand_voxel());
        end
    endtask

    // small random volumes, whole ones plus a cut-off tail
    task automatic test_random_volumes();
        int unsigned nx, ny, nz, vol, count;
        repeat (3) begin
            nx = $urandom_range(1, 6);
            ny = $urandom_range(1, 4);
            nz = $urandom_range(1, 3);
            vol = nx * ny * nz;
            // junk above the 8-bit size field, zero in place of one now and then
            write_reg(svt_pkg::CFG_SIZE_X, {3'($urandom_range(0, 7)),
                                   (nx == 1 && $urandom_range(0, 1)) ? 8'd0 : 8'(nx)});
            write_reg(svt_pkg::CFG_SIZE_Y, {3'($urandom_range(0, 7)), 8'(ny)});
            write_reg(svt_pkg::CFG_SIZE_Z, (nz == 1 && $urandom_range(0, 1)) ? 11'd0 : 11'(nz));
            no_gaps = ($urandom_range(0, 3) == 0);
            count = vol * $urandom_range(1, 2) + $urandom_range(0, vol);
            for (int i = 0; i < count; i++) begin
                if (i == vol / 2 && $urandom_range(0, 3) == 0)
                    write_reg(CFG_NO_REG, 11'($urandom_range(0, 2047)));
                send_voxel(rand_voxel());
            end
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // output stall pattern: always-ready stretches, random stalls and an occasional long stall
    initial begin
        m_tready <= 1'b0;
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 200)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(20, 100)) begin
                    m_tready <= ($urandom_range(0, 99) < 70);
                    @(posedge aclk);
                end
                if ($urandom_range(0, 4) == 0) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    // every accepted word is compared with the oldest pending integral
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sums_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual sum=%h last=%b",
                         $time, m_tdata, m_tlast);
            end else begin
                sum_want = sums_due.pop_front();
                if (m_tdata !== sum_want.sum) begin
                    errors++;
                    $display("%0t: volume_sum mismatch: expected %h, actual %h",
                             $time, sum_want.sum, m_tdata);
                end
                if (m_tlast !== sum_want.last) begin
                    errors++;
                    $display("%0t: last_voxel mismatch: expected %b, actual %b",
                             $time, sum_want.last, m_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        errors    = 0;
        no_gaps   = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        vol_x = MAX_X;
        vol_y = MAX_Y;
        vol_z = MAX_Z;
        restart_volume();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_sizes();
        test_directed();
        test_size_x_max();
        test_size_y_max();
        test_size_z_max();
        test_random_volumes();

        // drain, then allow for the pipeline depth in case of stray words
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (sums_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("PASS summed_volume_table_3d_top");
        else
            $display("FAIL summed_volume_table_3d_top");
        $finish;
    end

endmodule
